### hdl/crcfc_pkg.sv
// Shared types, constants and the CRC step for the CRC-16 frame checker.
package crcfc_pkg;

  localparam int MAX_PAYLOAD_DEFAULT = 64;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [6:0] PREFIX_BYTES = 7'd5;
  localparam logic [6:0] CRC_BYTES    = 7'd2;
  localparam logic [6:0] COUNT_MAX    = 7'd127;

  localparam logic [6:0] IDX_HEADER0 = 7'd0;
  localparam logic [6:0] IDX_HEADER1 = 7'd1;
  localparam logic [6:0] IDX_TYPE    = 7'd2;
  localparam logic [6:0] IDX_LEN_LO  = 7'd3;
  localparam logic [6:0] IDX_LEN_HI  = 7'd4;

  localparam logic [1:0] REG_HEADER_FIRST    = 2'd0;
  localparam logic [1:0] REG_HEADER_SECOND   = 2'd1;
  localparam logic [1:0] REG_EXPECTED_TYPE   = 2'd2;
  localparam logic [1:0] REG_EXPECTED_LENGTH = 2'd3;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SIZE      = 3'd1,
    ST_HEADER    = 3'd2,
    ST_TYPE_LEN  = 3'd3,
    ST_CRC       = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] header_first;
    logic [7:0] header_second;
    logic [7:0] expected_type;
    logic [6:0] expected_length;
  } cfg_t;

  typedef struct packed {
    logic       bank;
    logic [6:0] len;
    status_t    status;
  } desc_t;

  function automatic logic [15:0] crc_fold(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### hdl/crcfc_front.sv
// Receive side: header checks, CRC with two-byte hold-back, payload writes, frame verdict.
module crcfc_front import crcfc_pkg::*; #(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT,
  parameter int ADDR_W      = 7
) (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              accept,
  input  logic [7:0]        rx_byte,
  input  logic              end_of_frame,
  output logic              push,
  output desc_t             push_desc,
  output logic              wr_en,
  output logic [ADDR_W-1:0] wr_addr,
  output logic [7:0]        wr_data
);

  localparam int IDX_W = ADDR_W - 1;

  logic [15:0] crc_value;
  logic [6:0]  byte_count;
  logic [7:0]  held0;
  logic [7:0]  held1;
  logic        header_good;
  logic        type_length_good;
  logic        wr_bank;

  logic        header_good_next;
  logic        type_length_good_next;
  logic [15:0] crc_value_next;
  logic [6:0]  byte_count_next;
  logic [6:0]  pay_idx;
  logic [7:0]  want;
  logic [15:0] rx_crc;
  logic        size_bad;
  status_t     status;

  always_comb begin
    header_good_next = header_good;
    if (byte_count == IDX_HEADER0 && rx_byte != cfg.header_first) header_good_next = 1'b0;
    if (byte_count == IDX_HEADER1 && rx_byte != cfg.header_second) header_good_next = 1'b0;

    type_length_good_next = type_length_good;
    if (byte_count == IDX_TYPE && rx_byte != cfg.expected_type) type_length_good_next = 1'b0;
    if (byte_count == IDX_LEN_LO && rx_byte != {1'b0, cfg.expected_length}) begin
      type_length_good_next = 1'b0;
    end
    if (byte_count == IDX_LEN_HI && rx_byte != 8'd0) type_length_good_next = 1'b0;

    crc_value_next = (byte_count >= IDX_LEN_HI) ? crc_fold(crc_value, held0) : crc_value;
    byte_count_next = (byte_count < COUNT_MAX) ? byte_count + 7'd1 : byte_count;

    want = {1'b0, PREFIX_BYTES} + {1'b0, cfg.expected_length} + {1'b0, CRC_BYTES};
    rx_crc = {rx_byte, held1};

    size_bad = (cfg.expected_length == 7'd0) ||
               (cfg.expected_length > 7'(MAX_PAYLOAD)) ||
               (byte_count_next >= COUNT_MAX) ||
               ({1'b0, byte_count_next} != want);

    if (size_bad) begin
      status = ST_SIZE;
    end else if (!header_good_next) begin
      status = ST_HEADER;
    end else if (!type_length_good_next) begin
      status = ST_TYPE_LEN;
    end else if (rx_crc != crc_value_next) begin
      status = ST_CRC;
    end else begin
      status = ST_OK;
    end
  end

  assign pay_idx = byte_count - PREFIX_BYTES;
  assign wr_en   = accept && (byte_count >= PREFIX_BYTES) && (pay_idx < 7'(MAX_PAYLOAD));
  assign wr_addr = {wr_bank, pay_idx[IDX_W-1:0]};
  assign wr_data = rx_byte;

  assign push             = accept && end_of_frame;
  assign push_desc.bank   = wr_bank;
  assign push_desc.len    = cfg.expected_length;
  assign push_desc.status = status;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_value        <= CRC_INIT;
      byte_count       <= 7'd0;
      held0            <= 8'd0;
      held1            <= 8'd0;
      header_good      <= 1'b1;
      type_length_good <= 1'b1;
      wr_bank          <= 1'b0;
    end else if (accept) begin
      if (end_of_frame) begin
        crc_value        <= CRC_INIT;
        byte_count       <= 7'd0;
        held0            <= 8'd0;
        held1            <= 8'd0;
        header_good      <= 1'b1;
        type_length_good <= 1'b1;
        if (status == ST_OK) wr_bank <= ~wr_bank;
      end else begin
        crc_value        <= crc_value_next;
        byte_count       <= byte_count_next;
        held0            <= held1;
        held1            <= rx_byte;
        header_good      <= header_good_next;
        type_length_good <= type_length_good_next;
      end
    end
  end

endmodule

### hdl/crcfc_queue.sv
// Two-entry queue of frame verdicts between receive side and drain side.
module crcfc_queue import crcfc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  desc_t din,
  input  logic  pop,
  output desc_t dout,
  output logic  full,
  output logic  empty
);

  desc_t      entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign dout  = entries[rd_ptr];
  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### hdl/crcfc_drain.sv
// Drain side: two-bank payload store and result sequencer with output register.
module crcfc_drain import crcfc_pkg::*; #(
  parameter int ADDR_W = 7
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              empty,
  input  desc_t             head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_payload,
  output status_t           out_status,
  output logic              out_last
);

  localparam int IDX_W = ADDR_W - 1;
  localparam int DEPTH = 2 ** ADDR_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_SHOW = 3'b100
  } state_t;

  state_t            state;
  logic [7:0]        mem [DEPTH];
  logic [7:0]        rd_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [6:0]        k;
  logic [6:0]        k_inc;
  logic              more;
  logic              at_end;

  assign k_inc  = k + 7'd1;
  assign at_end = (k_inc == head.len);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = {head.bank, k_inc[IDX_W-1:0]};
    pop     = 1'b0;
    case (state)
      S_IDLE: begin
        if (!empty) begin
          if (head.status == ST_OK) begin
            rd_en   = 1'b1;
            rd_addr = {head.bank, {IDX_W{1'b0}}};
          end else begin
            pop = 1'b1;
          end
        end
      end
      S_READ: begin
        pop = at_end;
      end
      S_SHOW: begin
        rd_en = out_ready && more;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      more      <= 1'b0;
      k         <= 7'd0;
    end else begin
      case (state)
        S_IDLE: begin
          if (!empty) begin
            if (head.status == ST_OK) begin
              k     <= 7'd0;
              state <= S_READ;
            end else begin
              out_payload <= 8'd0;
              out_status  <= head.status;
              out_last    <= 1'b1;
              out_valid   <= 1'b1;
              more        <= 1'b0;
              state       <= S_SHOW;
            end
          end
        end
        S_READ: begin
          out_payload <= rd_data;
          out_status  <= ST_OK;
          out_last    <= at_end;
          out_valid   <= 1'b1;
          more        <= !at_end;
          state       <= S_SHOW;
        end
        S_SHOW: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (more) begin
              k     <= k_inc;
              state <= S_READ;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### hdl/crc16_frame_checker_unit.sv
// Top level: CRC-16 frame checker with APB register port and byte streams.
// Input: one byte per cycle while fewer than two frame verdicts wait; else stall.
// Output: when idle, each payload byte of a good frame is read from the store, then
// registered; an error result is registered directly. Next bytes wait for out_ready.
// An error frame gives one result. Reset is synchronous: frame state clears, registers
// return to defaults at once; the payload store is not cleared and needs no pass.
module crc16_frame_checker_unit import crcfc_pkg::*; #(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tlast,   // end_of_frame
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] payload_byte, [10:8] status, [15:11] zero
  output logic        m_axis_tlast    // is_last
);

  localparam int IDX_W  = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int ADDR_W = IDX_W + 1;

  cfg_t              cfg;
  logic              cfg_wr;
  logic              accept;
  logic              push;
  desc_t             push_desc;
  logic              pop;
  desc_t             head;
  logic              full;
  logic              empty;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic [7:0]        out_payload;
  status_t           out_status;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_first    <= 8'd0;
      cfg.header_second   <= 8'd0;
      cfg.expected_type   <= 8'd0;
      cfg.expected_length <= 7'd1;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_HEADER_FIRST:    cfg.header_first    <= pwdata[7:0];
        REG_HEADER_SECOND:   cfg.header_second   <= pwdata[7:0];
        REG_EXPECTED_TYPE:   cfg.expected_type   <= pwdata[7:0];
        REG_EXPECTED_LENGTH: cfg.expected_length <= pwdata[6:0];
        default:             cfg <= cfg;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_HEADER_FIRST:    prdata = {24'd0, cfg.header_first};
      REG_HEADER_SECOND:   prdata = {24'd0, cfg.header_second};
      REG_EXPECTED_TYPE:   prdata = {24'd0, cfg.expected_type};
      REG_EXPECTED_LENGTH: prdata = {25'd0, cfg.expected_length};
      default:             prdata = 32'd0;
    endcase
  end

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  crcfc_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .ADDR_W      (ADDR_W)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .accept       (accept),
    .rx_byte      (s_axis_tdata),
    .end_of_frame (s_axis_tlast),
    .push         (push),
    .push_desc    (push_desc),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data)
  );

  crcfc_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (push_desc),
    .pop   (pop),
    .dout  (head),
    .full  (full),
    .empty (empty)
  );

  crcfc_drain #(
    .ADDR_W (ADDR_W)
  ) u_drain (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .empty       (empty),
    .head        (head),
    .pop         (pop),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_payload (out_payload),
    .out_status  (out_status),
    .out_last    (m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, out_status, out_payload};

endmodule
